>>> rtl/core/ulc_pkg.sv
`default_nettype none
package ulc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_WRAP_WIDTH  = 3'd2;
  localparam logic [2:0] REG_GLYPH_SCALE = 3'd3;
  localparam logic [2:0] REG_WRAP_ENABLE = 3'd4;
  localparam logic [2:0] REG_TEXT_COLOR  = 3'd5;

  localparam logic [15:0] CHAR_NEWLINE  = 16'h000A;
  localparam logic [15:0] CHAR_QUESTION = 16'h003F;

  // utf-8 lead byte patterns
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_MATCH = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_MATCH = 8'hE0;

  // layout configuration seen by the back end
  typedef struct packed {
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic [10:0]        wrap_width;
    logic [3:0]         glyph_scale;
    logic               wrap_enable;
    logic [15:0]        text_color;
  } ulc_cfg_t;

  // one decoded event from the front end
  typedef struct packed {
    logic        restart;
    logic        has_char;
    logic [15:0] code;
  } ulc_entry_t;

  // the listed accented capitals fold to plain capitals
  function automatic logic [15:0] fold_capital(input logic [15:0] c);
    logic [15:0] r;
    r = c;
    unique case (c)
      16'h00C0, 16'h00C2:          r = 16'h0041;
      16'h00C7:                    r = 16'h0043;
      16'h00C8, 16'h00C9, 16'h00CA: r = 16'h0045;
      16'h00CE:                    r = 16'h0049;
      16'h00D4:                    r = 16'h004F;
      16'h00D9, 16'h00DB:          r = 16'h0055;
      default:                     r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/ulc_front.sv
`default_nettype none
module ulc_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_take,
  input  wire logic [7:0]          text_byte,
  input  wire logic                begin_string,
  output logic                     push,
  output ulc_pkg::ulc_entry_t      entry
);
  import ulc_pkg::*;

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [15:0] partial_code, partial_code_next;
  logic [1:0]  pend_eff;
  logic [15:0] part_eff;
  logic [15:0] shifted;
  logic        has_char;
  logic [15:0] char_raw;

  // utf-8 decode step for one byte
  always_comb begin
    pend_eff = begin_string ? 2'd0 : bytes_pending;
    part_eff = begin_string ? 16'd0 : partial_code;
    shifted  = {part_eff[9:0], text_byte[5:0]};
    bytes_pending_next = pend_eff;
    partial_code_next  = part_eff;
    has_char = 1'b0;
    char_raw = {8'd0, text_byte};
    if (text_byte == 8'd0) begin
      has_char = 1'b0;
    end else if (pend_eff != 2'd0) begin
      bytes_pending_next = pend_eff - 2'd1;
      if (pend_eff == 2'd1) begin
        has_char = 1'b1;
        char_raw = shifted;
        partial_code_next = 16'd0;
      end else begin
        partial_code_next = shifted;
      end
    end else if (!text_byte[7]) begin
      has_char = 1'b1;
    end else if ((text_byte & LEAD2_MASK) == LEAD2_MATCH) begin
      partial_code_next  = {11'd0, text_byte[4:0]};
      bytes_pending_next = 2'd1;
    end else if ((text_byte & LEAD3_MASK) == LEAD3_MATCH) begin
      partial_code_next  = {12'd0, text_byte[3:0]};
      bytes_pending_next = 2'd2;
    end else begin
      has_char = 1'b1;
      char_raw = CHAR_QUESTION;
    end
  end

  // queue entry for a restart or a finished character
  always_comb begin
    entry.restart  = begin_string;
    entry.has_char = has_char;
    entry.code     = fold_capital(char_raw);
    push           = in_take && (begin_string || has_char);
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_code  <= 16'd0;
    end else if (in_take) begin
      bytes_pending <= bytes_pending_next;
      partial_code  <= partial_code_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ulc_fifo.sv
`default_nettype none
module ulc_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ulc_pkg::ulc_entry_t din,
  output logic                     full,
  input  wire logic                pop,
  output ulc_pkg::ulc_entry_t      dout,
  output logic                     not_empty
);
  import ulc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ulc_entry_t      slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign dout      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ulc_back.sv
`default_nettype none
module ulc_back #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ulc_pkg::ulc_cfg_t        cfg,
  input  wire logic                     q_valid,
  input  wire ulc_pkg::ulc_entry_t      q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [15:0]                   out_code,
  output logic [COORD_BITS-1:0]         out_x,
  output logic [COORD_BITS-1:0]         out_y,
  output logic [15:0]                   out_color
);
  import ulc_pkg::*;

  localparam int W = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
  localparam logic signed [W-1:0] SAT_HI = W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [W-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [COORD_BITS-1:0] sat(input logic signed [W-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  logic signed [COORD_BITS-1:0] cursor_x, cursor_y;
  logic signed [COORD_BITS-1:0] cursor_x_next, cursor_y_next;
  logic signed [COORD_BITS-1:0] ox_sat, oy_sat, cx0, cy0, cx1, cy1;
  logic signed [W-1:0] adv8, pitch, limit, cx0_w, reach, y_down, x_step;
  logic is_nl, over, brk, emit, load;

  // origin and scale terms
  always_comb begin
    ox_sat = sat(W'(cfg.origin_x));
    oy_sat = sat(W'(cfg.origin_y));
    adv8   = W'({cfg.glyph_scale, 3'b000});
    pitch  = W'({cfg.glyph_scale, 3'b000}) + W'({cfg.glyph_scale, 1'b0});
    limit  = W'(cfg.wrap_width);
  end

  // cursor placement and wrap for the head entry
  always_comb begin
    cx0    = q_entry.restart ? ox_sat : cursor_x;
    cy0    = q_entry.restart ? oy_sat : cursor_y;
    cx0_w  = W'(cx0);
    reach  = cx0_w + adv8;
    is_nl  = cfg.wrap_enable && (q_entry.code == CHAR_NEWLINE);
    over   = cfg.wrap_enable && (reach > limit);
    brk    = q_entry.has_char && (is_nl || over);
    y_down = W'(cy0) + pitch;
    cx1    = brk ? ox_sat : cx0;
    cy1    = brk ? sat(y_down) : cy0;
    emit   = q_entry.has_char && !is_nl;
    x_step = W'(cx1) + adv8 + W'(2);
    cursor_x_next = emit ? sat(x_step) : cx1;
    cursor_y_next = cy1;
    q_pop  = q_valid && (!out_valid || out_ready);
    load   = q_pop && emit;
  end

  // cursor state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x  <= '0;
      cursor_y  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      out_code  <= q_entry.code;
      out_x     <= cx1;
      out_y     <= cy1;
      out_color <= cfg.text_color;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/utf8_text_layout_cursor.sv
// a byte that completes a character is written into the queue, then into the output register driving m_tdata
// throughput: one byte per cycle while the queue has room; the front decoder and the back cursor unit
//   each take one item a cycle unless stalled, and a four-entry queue between them absorbs output stalls
// reset (rst, synchronous): decoder and cursor state cleared, queue and output emptied,
//   registers return to origin 0,0 / width 640 / scale 1 / wrap on / colour 0xFFFF
`default_nettype none
module utf8_text_layout_cursor #(
  parameter int COORD_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // text_byte
  input  wire logic        s_tuser,  // begin_string
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // code_point[15:0], pos_x, pos_y, color, zero pad to whole bytes
  output logic [((32 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
  import ulc_pkg::*;

  localparam int DATA_BITS = 32 + 2 * COORD_BITS;
  localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

  ulc_cfg_t   cfg;
  ulc_entry_t f_entry, q_entry;
  logic       f_push, q_full, q_valid, q_pop, in_take, cfg_wr;
  logic [2:0] reg_idx;
  logic [15:0]           out_code, out_color;
  logic [COORD_BITS-1:0] out_x, out_y;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= 12'sd0;
      cfg.origin_y    <= 12'sd0;
      cfg.wrap_width  <= 11'd640;
      cfg.glyph_scale <= 4'd1;
      cfg.wrap_enable <= 1'b1;
      cfg.text_color  <= 16'hFFFF;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_X:    cfg.origin_x    <= pwdata[11:0];
        REG_ORIGIN_Y:    cfg.origin_y    <= pwdata[11:0];
        REG_WRAP_WIDTH:  cfg.wrap_width  <= pwdata[10:0];
        REG_GLYPH_SCALE: cfg.glyph_scale <= pwdata[3:0];
        REG_WRAP_ENABLE: cfg.wrap_enable <= pwdata[0];
        REG_TEXT_COLOR:  cfg.text_color  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:    prdata = {20'd0, cfg.origin_x};
      REG_ORIGIN_Y:    prdata = {20'd0, cfg.origin_y};
      REG_WRAP_WIDTH:  prdata = {21'd0, cfg.wrap_width};
      REG_GLYPH_SCALE: prdata = {28'd0, cfg.glyph_scale};
      REG_WRAP_ENABLE: prdata = {31'd0, cfg.wrap_enable};
      REG_TEXT_COLOR:  prdata = {16'd0, cfg.text_color};
      default:         prdata = 32'd0;
    endcase
  end

  // input acceptance follows queue space
  assign s_tready = !q_full;
  assign in_take  = s_tvalid && s_tready;

  ulc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_take      (in_take),
    .text_byte    (s_tdata),
    .begin_string (s_tuser),
    .push         (f_push),
    .entry        (f_entry)
  );

  ulc_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .din       (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_entry),
    .not_empty (q_valid)
  );

  ulc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_code  (out_code),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_color (out_color)
  );

  // result packing
  assign m_tdata = TDATA_W'({out_color, out_y, out_x, out_code});

endmodule
`default_nettype wire
